// File: hw/rtl/gbn_pkg.sv
`default_nettype none
package gbn_pkg;

   localparam int SEQ_W  = 16;

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_TICK  = 2'd1,
      OP_ACK   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_WINDOW  = 2'd0,
      CSR_TOTAL   = 2'd1,
      CSR_START   = 2'd2,
      CSR_TIMEOUT = 2'd3
   } csr_index_type;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_START = 5'b00010,
      PH_DATA  = 5'b00100,
      PH_END   = 5'b01000,
      PH_DONE  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [SEQ_W-1:0] a;
      logic [SEQ_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [SEQ_W:0] sum;
      logic           lt;
   } alu_rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/gbn_if.sv
`default_nettype none
interface gbn_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic        ack_is_ack;
   logic [15:0] ack_sequence;

   modport source (output valid, operation, ack_is_ack, ack_sequence, input ready);
   modport sink   (input valid, operation, ack_is_ack, ack_sequence, output ready);
endinterface

interface gbn_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  packet_kind;
   logic [15:0] packet_sequence;
   logic        last_of_run;
   logic        transfer_done;

   modport source (output valid, packet_kind, packet_sequence, last_of_run,
                   transfer_done, input ready);
   modport sink   (input valid, packet_kind, packet_sequence, last_of_run,
                   transfer_done, output ready);
endinterface

interface gbn_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/go_back_n_sender_window_unit.sv
`default_nettype none
// An accepted request is decoded first. Begin then goes to SEND for its START request;
// tick to TICK and, on timeout, to SEND or a refill; ack to SEND, to a refill, or through
// ACK_CLAMP, ACK_BASE and ACK_DRAIN, which may go on to a refill. A refill runs WIN (or
// SEND for END), LIMIT, CLAMP, then FILL: one DATA request per cycle while rsp is taken.
// A new input request is taken only in IDLE; each step uses the single shared unit.
// Reset (synchronous, active high): phase idle, counters zero, CSR registers to defaults.
module go_back_n_sender_window_unit #(
   parameter int MAX_WINDOW = 32
) (
   input  wire       clock,
   input  wire       reset,
   gbn_req_if.sink   req,
   gbn_rsp_if.source rsp,
   gbn_csr_if.sink   csr
);

   localparam int WIN_W = $clog2(MAX_WINDOW + 1) > 6 ? $clog2(MAX_WINDOW + 1) : 6;
   localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_WINDOW);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b00000000001,
      S_DECODE    = 11'b00000000010,
      S_TICK      = 11'b00000000100,
      S_ACK_CLAMP = 11'b00000001000,
      S_ACK_BASE  = 11'b00000010000,
      S_ACK_DRAIN = 11'b00000100000,
      S_WIN       = 11'b00001000000,
      S_LIMIT     = 11'b00010000000,
      S_CLAMP     = 11'b00100000000,
      S_FILL      = 11'b01000000000,
      S_SEND      = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   gbn_pkg::phase_type phase_ff, phase_in;

   logic [5:0]  window_ff;
   logic [15:0] total_ff;
   logic [13:0] start_seq_ff;
   logic [15:0] timeout_ff;

   logic [15:0] base_ff, base_in;
   logic [15:0] next_ff, next_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] opnd_ff, opnd_in;

   logic [1:0]  op_ff;
   logic        is_ack_ff;
   logic [15:0] aseq_ff;

   logic [1:0]  pend_kind_ff, pend_kind_in;
   logic [15:0] pend_seq_ff, pend_seq_in;
   logic        pend_done_ff, pend_done_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_seq_ff, rsp_seq_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_done_ff, rsp_done_in;

   gbn_pkg::alu_req_type alu_req;
   gbn_pkg::alu_rsp_type alu_rsp;

   logic [WIN_W-1:0] win_ext;
   logic [WIN_W-1:0] eff_win;
   logic [15:0]      start_seq16;
   logic             slot_free;
   logic             match;
   logic             accept;
   logic [16:0]      next_inc;

   gbn_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign start_seq16 = {2'b00, start_seq_ff};
   assign win_ext     = WIN_W'(window_ff);
   assign eff_win     = (window_ff == 6'd0) ? WIN_W'(1) :
                        (win_ext > WIN_MAX) ? WIN_MAX : win_ext;
   assign slot_free   = !rsp_valid_ff || rsp.ready;
   assign match       = is_ack_ff && (aseq_ff == start_seq16);
   assign next_inc    = {1'b0, next_ff} + 17'd1;
   assign req.ready   = (state_ff == S_IDLE);
   assign accept      = req.valid && req.ready;
   assign csr.ready   = 1'b1;

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.packet_kind     = rsp_kind_ff;
   assign rsp.packet_sequence = rsp_seq_ff;
   assign rsp.last_of_run     = rsp_last_ff;
   assign rsp.transfer_done   = rsp_done_ff;

   // operand select for the shared unit
   always_comb begin
      alu_req.a = 16'd0;
      alu_req.b = 16'd0;
      case (state_ff)
         S_DECODE: begin
            alu_req.a = elapsed_ff;
            alu_req.b = 16'd1;
         end
         S_TICK: begin
            alu_req.a = elapsed_ff;
            alu_req.b = timeout_ff;
         end
         S_ACK_CLAMP: begin
            alu_req.a = aseq_ff;
            alu_req.b = next_ff;
         end
         S_ACK_BASE: begin
            alu_req.a = base_ff;
            alu_req.b = opnd_ff;
         end
         S_ACK_DRAIN: begin
            alu_req.a = base_ff;
            alu_req.b = next_ff;
         end
         S_WIN: begin
            alu_req.a = base_ff;
            alu_req.b = total_ff;
         end
         S_LIMIT: begin
            alu_req.a = base_ff;
            alu_req.b = 16'(eff_win);
         end
         S_CLAMP: begin
            alu_req.a = total_ff;
            alu_req.b = opnd_ff;
         end
         S_FILL: begin
            alu_req.a = next_ff;
            alu_req.b = opnd_ff;
         end
         default: begin
            alu_req.a = 16'd0;
            alu_req.b = 16'd0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      elapsed_in   = elapsed_ff;
      opnd_in      = opnd_ff;
      pend_kind_in = pend_kind_ff;
      pend_seq_in  = pend_seq_ff;
      pend_done_in = pend_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in     = S_IDLE;
            pend_done_in = 1'b0;
            pend_seq_in  = start_seq16;
            case (op_ff)
               gbn_pkg::OP_BEGIN: begin
                  phase_in     = gbn_pkg::PH_START;
                  base_in      = 16'd0;
                  next_in      = 16'd0;
                  elapsed_in   = 16'd0;
                  pend_kind_in = gbn_pkg::KIND_START;
                  state_in     = S_SEND;
               end
               gbn_pkg::OP_TICK: begin
                  if (phase_ff == gbn_pkg::PH_START || phase_ff == gbn_pkg::PH_DATA ||
                      phase_ff == gbn_pkg::PH_END) begin
                     // saturate at all ones
                     if (!alu_rsp.sum[16]) begin
                        elapsed_in = alu_rsp.sum[15:0];
                     end
                     state_in = S_TICK;
                  end
               end
               gbn_pkg::OP_ACK: begin
                  if (phase_ff == gbn_pkg::PH_START) begin
                     elapsed_in = 16'd0;
                     if (match) begin
                        phase_in = gbn_pkg::PH_DATA;
                        base_in  = 16'd0;
                        next_in  = 16'd0;
                        state_in = S_WIN;
                     end else begin
                        pend_kind_in = gbn_pkg::KIND_START;
                        state_in     = S_SEND;
                     end
                  end else if (phase_ff == gbn_pkg::PH_END) begin
                     elapsed_in = 16'd0;
                     if (match) begin
                        phase_in     = gbn_pkg::PH_DONE;
                        pend_kind_in = gbn_pkg::KIND_START;
                        pend_seq_in  = 16'd0;
                        pend_done_in = 1'b1;
                     end else begin
                        pend_kind_in = gbn_pkg::KIND_END;
                     end
                     state_in = S_SEND;
                  end else if (phase_ff == gbn_pkg::PH_DATA && is_ack_ff) begin
                     state_in = S_ACK_CLAMP;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_TICK: begin
            state_in = S_IDLE;
            if (!alu_rsp.lt) begin
               elapsed_in   = 16'd0;
               pend_seq_in  = start_seq16;
               pend_done_in = 1'b0;
               if (phase_ff == gbn_pkg::PH_START) begin
                  pend_kind_in = gbn_pkg::KIND_START;
                  state_in     = S_SEND;
               end else if (phase_ff == gbn_pkg::PH_END) begin
                  pend_kind_in = gbn_pkg::KIND_END;
                  state_in     = S_SEND;
               end else begin
                  // rewind and resend the window
                  next_in  = base_ff;
                  state_in = S_WIN;
               end
            end
         end
         S_ACK_CLAMP: begin
            opnd_in  = alu_rsp.lt ? aseq_ff : next_ff;
            state_in = S_ACK_BASE;
         end
         S_ACK_BASE: begin
            if (alu_rsp.lt) begin
               base_in    = opnd_ff;
               elapsed_in = 16'd0;
            end
            state_in = S_ACK_DRAIN;
         end
         S_ACK_DRAIN: begin
            if (alu_rsp.lt) begin
               state_in = S_IDLE;
            end else begin
               elapsed_in = 16'd0;
               state_in   = S_WIN;
            end
         end
         S_WIN: begin
            if (alu_rsp.lt) begin
               state_in = S_LIMIT;
            end else begin
               phase_in     = gbn_pkg::PH_END;
               pend_kind_in = gbn_pkg::KIND_END;
               pend_seq_in  = start_seq16;
               pend_done_in = 1'b0;
               state_in     = S_SEND;
            end
         end
         S_LIMIT: begin
            // base < total, so the sum fits in 16 bits once clamped
            opnd_in  = alu_rsp.sum[16] ? 16'hFFFF : alu_rsp.sum[15:0];
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            if (alu_rsp.lt) begin
               opnd_in = total_ff;
            end
            state_in = S_FILL;
         end
         S_FILL: begin
            if (!alu_rsp.lt) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = gbn_pkg::KIND_DATA;
               rsp_seq_in   = next_ff;
               rsp_last_in  = (next_inc == {1'b0, opnd_ff});
               rsp_done_in  = 1'b0;
               next_in      = next_inc[15:0];
               if (next_inc == {1'b0, opnd_ff}) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SEND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_seq_in   = pend_seq_ff;
               rsp_last_in  = 1'b1;
               rsp_done_in  = pend_done_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= gbn_pkg::PH_IDLE;
         base_ff      <= 16'd0;
         next_ff      <= 16'd0;
         elapsed_ff   <= 16'd0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= 6'd4;
         total_ff     <= 16'd0;
         start_seq_ff <= 14'd0;
         timeout_ff   <= 16'd500;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.ready) begin
            case (csr.index)
               gbn_pkg::CSR_WINDOW:  window_ff    <= csr.data[5:0];
               gbn_pkg::CSR_TOTAL:   total_ff     <= csr.data;
               gbn_pkg::CSR_START:   start_seq_ff <= csr.data[13:0];
               gbn_pkg::CSR_TIMEOUT: timeout_ff   <= csr.data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      opnd_ff      <= opnd_in;
      pend_kind_ff <= pend_kind_in;
      pend_seq_ff  <= pend_seq_in;
      pend_done_ff <= pend_done_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
      if (accept) begin
         op_ff     <= req.operation;
         is_ack_ff <= req.ack_is_ack;
         aseq_ff   <= req.ack_sequence;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/gbn_alu.sv
`default_nettype none
module gbn_alu (
   input  wire gbn_pkg::alu_req_type alu_req,
   output gbn_pkg::alu_rsp_type      alu_rsp
);

   always_comb begin
      alu_rsp.sum = {1'b0, alu_req.a} + {1'b0, alu_req.b};
      alu_rsp.lt  = (alu_req.a < alu_req.b);
   end

endmodule
`default_nettype wire
